// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AST_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Signal must be low in the cycle after reset is seen.
`define AST_RESET_LOW(lbl, clk, rst, sig) \
   lbl: assert property (@(posedge clk) (rst) |=> !(sig)) \
      else $error("assertion failed");

`endif

// ===== hdl/u8e_pkg.sv =====
// Shared types and constants of the UTF-8 to single-byte encoder.
package u8e_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [7:0] DEFAULT_BYTE_RESET = 8'd63;

   // Register index (paddr[2])
   localparam logic CSR_DEFAULT_BYTE = 1'b0;

   // Request commands
   localparam logic [1:0] CMD_UTF8   = 2'd0;
   localparam logic [1:0] CMD_WR_FH  = 2'd1;
   localparam logic [1:0] CMD_WR_IDX = 2'd2;
   localparam logic [1:0] CMD_WR_DEC = 2'd3;

   localparam int CP_W  = 21;
   localparam int IDX_W = 7;

   typedef enum logic [2:0] {
      KIND_WR_FH,
      KIND_WR_IDX,
      KIND_WR_DEC,
      KIND_LOOKUP,
      KIND_EMIT
   } kind_type;

   // One queued job: a table write, a code point lookup or a direct byte
   typedef struct packed {
      kind_type           kind;
      logic               err;
      logic [IDX_W-1:0]   ti;
      logic [CP_W-1:0]    val;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hdl/u8e_front.sv =====
// Front end: decodes UTF-8 requests into queued jobs.
module u8e_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              req_command,
   input  logic [7:0]              req_data_byte,
   input  logic [6:0]              req_table_index,
   input  logic [20:0]             req_table_value,
   output logic                    push,
   output u8e_pkg::item_type       item
);

   logic [20:0] acc_ff, acc_in;
   logic [1:0]  rem_ff, rem_in;
   logic [1:0]  len_ff, len_in;
   logic        emit;
   logic [20:0] acc_next;
   logic [20:0] minimum;
   logic        bad;

   always_comb begin
      acc_next = {acc_ff[14:0], req_data_byte[5:0]};
      case (len_ff)
         2'd1:    minimum = 21'h00080;
         2'd2:    minimum = 21'h00800;
         default: minimum = 21'h10000;
      endcase
      bad = (acc_next < minimum) || (acc_next >= 21'h0D800 && acc_next <= 21'h0DFFF)
            || (acc_next > 21'h10FFFF);
   end

   always_comb begin
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      len_in    = len_ff;
      emit      = 1'b0;
      item.kind = u8e_pkg::KIND_EMIT;
      item.err  = 1'b0;
      item.ti   = req_table_index;
      item.val  = req_table_value;
      unique case (req_command)
         u8e_pkg::CMD_WR_FH: begin
            emit      = 1'b1;
            item.kind = u8e_pkg::KIND_WR_FH;
         end
         u8e_pkg::CMD_WR_IDX: begin
            emit      = 1'b1;
            item.kind = u8e_pkg::KIND_WR_IDX;
         end
         u8e_pkg::CMD_WR_DEC: begin
            emit      = 1'b1;
            item.kind = u8e_pkg::KIND_WR_DEC;
         end
         u8e_pkg::CMD_UTF8: begin
            item.val = {13'd0, req_data_byte};
            if (rem_ff == 2'd0) begin
               if (!req_data_byte[7]) begin
                  emit = 1'b1;
               end else if (req_data_byte[7:6] == 2'b10 || req_data_byte[7:3] == 5'b11111) begin
                  emit     = 1'b1;
                  item.err = 1'b1;
               end else if (req_data_byte[7:5] == 3'b110) begin
                  acc_in = {16'd0, req_data_byte[4:0]};
                  len_in = 2'd1;
                  rem_in = 2'd1;
               end else if (req_data_byte[7:4] == 4'b1110) begin
                  acc_in = {17'd0, req_data_byte[3:0]};
                  len_in = 2'd2;
                  rem_in = 2'd2;
               end else begin
                  acc_in = {18'd0, req_data_byte[2:0]};
                  len_in = 2'd3;
                  rem_in = 2'd3;
               end
            end else if (req_data_byte[7:6] != 2'b10) begin
               // interrupted sequence: drop the byte and return to idle
               emit     = 1'b1;
               item.err = 1'b1;
               acc_in   = '0;
               rem_in   = '0;
               len_in   = '0;
            end else begin
               acc_in = acc_next;
               rem_in = rem_ff - 2'd1;
               if (rem_ff == 2'd1) begin
                  emit   = 1'b1;
                  acc_in = '0;
                  len_in = '0;
                  if (bad) begin
                     item.err = 1'b1;
                  end else begin
                     item.kind = u8e_pkg::KIND_LOOKUP;
                     item.val  = acc_next;
                  end
               end
            end
         end
      endcase
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rem_ff <= '0;
         len_ff <= '0;
      end else if (accept) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         len_ff <= len_in;
      end
   end

endmodule

// ===== hdl/u8e_queue.sv =====
// Short job queue between the front end and the lookup pipeline.
module u8e_queue #(
   parameter int DEPTH = u8e_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  u8e_pkg::item_type         push_item,
   input  logic                      pop,
   output u8e_pkg::item_type         head,
   output u8e_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   u8e_pkg::item_type slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/u8e_back.sv =====
// Back end: table writes and the three-stage hash lookup with output register.
module u8e_back (
   input  logic                       clock,
   input  logic                       reset,
   input  u8e_pkg::item_type          head,
   input  u8e_pkg::queue_status_type  status,
   input  logic [7:0]                 default_byte,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_utf8_error
);

   logic [7:0]  fh_mem  [128];
   logic [6:0]  idx_mem [128];
   logic [20:0] dec_mem [128];

   logic              adv;
   logic              a_valid_ff, b_valid_ff, c_valid_ff;
   u8e_pkg::item_type a_item_ff, b_item_ff, c_item_ff;
   logic [7:0]        fh_rd_ff;
   logic [6:0]        idx_rd_ff;
   logic [6:0]        c_idx_ff;
   logic [20:0]       dec_rd_ff;
   logic [20:0]       shifted;
   logic [6:0]        h2;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              err_ff, err_in;

   // Whole pipeline advances together; it holds only while a result waits
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !status.empty;

   // Second hash from the first table entry: salted or direct
   always_comb begin
      shifted = (fh_rd_ff[6:5] == 2'b00) ? (a_item_ff.val >> fh_rd_ff[4:0]) : '0;
      h2      = fh_rd_ff[7] ? (a_item_ff.val[6:0] ^ shifted[6:0]) : fh_rd_ff[6:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (!status.empty && head.kind == u8e_pkg::KIND_WR_FH) begin
            fh_mem[head.ti] <= head.val[7:0];
         end
         fh_rd_ff <= fh_mem[head.val[6:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (a_valid_ff && a_item_ff.kind == u8e_pkg::KIND_WR_IDX) begin
            idx_mem[a_item_ff.ti] <= a_item_ff.val[6:0];
         end
         idx_rd_ff <= idx_mem[h2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (b_valid_ff && b_item_ff.kind == u8e_pkg::KIND_WR_DEC) begin
            dec_mem[b_item_ff.ti] <= b_item_ff.val;
         end
         dec_rd_ff <= dec_mem[idx_rd_ff];
      end
   end

   always_comb begin
      rsp_valid_in = c_valid_ff &&
                     (c_item_ff.kind == u8e_pkg::KIND_EMIT ||
                      c_item_ff.kind == u8e_pkg::KIND_LOOKUP);
      err_in       = c_item_ff.err && c_item_ff.kind == u8e_pkg::KIND_EMIT;
      if (err_in) begin
         out_byte_in = default_byte;
      end else if (c_item_ff.val[20:7] == '0) begin
         out_byte_in = c_item_ff.val[7:0];
      end else if (dec_rd_ff == c_item_ff.val) begin
         out_byte_in = {1'b1, c_idx_ff};
      end else begin
         out_byte_in = default_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= !status.empty;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_item_ff   <= head;
         b_item_ff   <= a_item_ff;
         c_item_ff   <= b_item_ff;
         c_idx_ff    <= idx_rd_ff;
         out_byte_ff <= out_byte_in;
         err_ff      <= err_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_utf8_error = err_ff;

endmodule

// ===== hdl/utf8_to_single_byte_charset_encoder_unit.sv =====
// Top level of the UTF-8 to single-byte character set encoder.
//
//   channel   handshake          payload
//   req       req_valid/ready    req_command, req_data_byte, req_table_index,
//                                req_table_value
//   rsp       rsp_valid/ready    rsp_out_byte, rsp_utf8_error
//   csr       psel/penable       paddr, pwrite, pwdata, prdata, pready
//
// One request per cycle while the queue is not full; the front decodes in the
// accept cycle, the queue registers the job, and the three table-read stages
// plus the output register carry it on to the result.
// Synchronous reset clears decoder state, queue and pipeline valids and loads
// the default byte; the tables stay undefined until written.
// A held result stalls the lookup pipeline; requests keep entering until the
// queue (QUEUE_DEPTH jobs) fills.
module utf8_to_single_byte_charset_encoder_unit #(
   parameter int QUEUE_DEPTH = u8e_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic [6:0]  req_table_index,
   input  logic [20:0] req_table_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_utf8_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                       accept;
   logic                       push;
   logic                       pop;
   u8e_pkg::item_type          push_item;
   u8e_pkg::item_type          head;
   u8e_pkg::queue_status_type  status;
   logic [7:0]                 default_byte_ff;

   assign pready    = 1'b1;
   assign req_ready = !status.full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_byte_ff <= u8e_pkg::DEFAULT_BYTE_RESET;
      end else if (psel && penable && pwrite && paddr[2] == u8e_pkg::CSR_DEFAULT_BYTE) begin
         default_byte_ff <= pwdata[7:0];
      end
   end

   assign prdata = (paddr[2] == u8e_pkg::CSR_DEFAULT_BYTE) ? {24'd0, default_byte_ff} : '0;

   u8e_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .push            (push),
      .item            (push_item)
   );

   u8e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   u8e_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .status         (status),
      .default_byte   (default_byte_ff),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_utf8_error (rsp_utf8_error)
   );

endmodule

// ===== hdl/u8e_checker.sv =====
// Port-level checks for the encoder top level.
`include "assert_macros.svh"

module u8e_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_utf8_error,
   input logic       pready
);

   logic [8:0] rsp_payload;

   assign rsp_payload = {rsp_out_byte, rsp_utf8_error};

   `AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   `AST_RESET_LOW(a_rsp_reset, clock, reset, rsp_valid)

   `AST_SAME(a_pready_high, clock, reset, 1'b1, pready)

   // The queue fills only while the lookup pipeline is held by a waiting result
   `AST_SAME(a_full_needs_stall, clock, reset, !req_ready, $past(rsp_valid && !rsp_ready))

endmodule

bind utf8_to_single_byte_charset_encoder_unit u8e_checker u_checker (.*);

// ===== verif/utf8_to_single_byte_charset_encoder_unit_tb.sv =====
// Self-checking testbench for the UTF-8 to single-byte character set encoder.
`timescale 1ns / 100ps

module utf8_to_single_byte_charset_encoder_unit_tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [2:0] ADDR_DEFAULT_BYTE = {u8e_pkg::CSR_DEFAULT_BYTE, 2'b00};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       utf8_error;
   } encoded_char_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = u8e_pkg::CMD_UTF8;
   logic [7:0]  req_data_byte = '0;
   logic [6:0]  req_table_index = '0;
   logic [20:0] req_table_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_utf8_error;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Encoder state as seen from outside
   logic [7:0]  fh_model [128];
   logic [6:0]  index_model [128];
   logic [20:0] decode_model [128];
   logic [20:0] cp_acc = '0;
   logic [1:0]  cont_left = '0;
   logic [1:0]  cont_total = '0;
   logic [7:0]  default_byte_model = u8e_pkg::DEFAULT_BYTE_RESET;

   encoded_char_type expected_chars [$];
   int  mismatches = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_stalls_on = 1'b1;
   int  rsp_hold_request = 0;

   utf8_to_single_byte_charset_encoder_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_utf8_error  (rsp_utf8_error),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [6:0] second_hash(logic [20:0] cp, logic [7:0] entry);
      logic [20:0] mixed;
      if (!entry[7]) return entry[6:0];
      mixed = (entry[6:0] < 7'd32) ? (cp ^ (cp >> entry[6:0])) : cp;
      return mixed[6:0];
   endfunction

   function automatic logic [7:0] map_code_point(logic [20:0] cp);
      logic [6:0] slot;
      if (cp < 21'h80) return cp[7:0];
      slot = index_model[second_hash(cp, fh_model[cp[6:0]])];
      if (decode_model[slot] != cp) return default_byte_model;
      return {1'b1, slot};
   endfunction

   function automatic void flag_utf8_error();
      cp_acc = '0;
      cont_left = '0;
      cont_total = '0;
      expected_chars.push_back('{default_byte_model, 1'b1});
   endfunction

   function automatic void encode_request(logic [1:0] cmd, logic [7:0] b,
                                          logic [6:0] ti, logic [20:0] tv);
      logic [20:0] cp;
      logic [20:0] cp_floor;
      logic        bad;
      case (cmd)
         u8e_pkg::CMD_WR_FH:  fh_model[ti] = tv[7:0];
         u8e_pkg::CMD_WR_IDX: index_model[ti] = tv[6:0];
         u8e_pkg::CMD_WR_DEC: decode_model[ti] = tv;
         u8e_pkg::CMD_UTF8: begin
            if (cont_left == 2'd0) begin
               if (b < 8'h80) begin
                  expected_chars.push_back('{b, 1'b0});
               end else if (b < 8'hC0 || b >= 8'hF8) begin
                  flag_utf8_error();
               end else if (b < 8'hE0) begin
                  cp_acc = {16'd0, b[4:0]};
                  cont_total = 2'd1;
                  cont_left = 2'd1;
               end else if (b < 8'hF0) begin
                  cp_acc = {17'd0, b[3:0]};
                  cont_total = 2'd2;
                  cont_left = 2'd2;
               end else begin
                  cp_acc = {18'd0, b[2:0]};
                  cont_total = 2'd3;
                  cont_left = 2'd3;
               end
            end else if (b[7:6] != 2'b10) begin
               flag_utf8_error();
            end else begin
               cp_acc = {cp_acc[14:0], b[5:0]};
               cont_left = cont_left - 2'd1;
               if (cont_left == 2'd0) begin
                  cp = cp_acc;
                  cp_floor = (cont_total == 2'd1) ? 21'h80 :
                             (cont_total == 2'd2) ? 21'h800 : 21'h10000;
                  bad = cp < cp_floor || (cp >= 21'hD800 && cp <= 21'hDFFF) ||
                        cp > 21'h10FFFF;
                  cp_acc = '0;
                  cont_total = '0;
                  if (bad)
                     flag_utf8_error();
                  else
                     expected_chars.push_back('{map_code_point(cp), 1'b0});
               end
            end
         end
      endcase
   endfunction

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      encoded_char_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            note_mismatch("result with nothing expected", 0, 32'(rsp_out_byte));
         end else begin
            head = expected_chars.pop_front();
            if (rsp_out_byte !== head.out_byte)
               note_mismatch("out_byte", 32'(head.out_byte), 32'(rsp_out_byte));
            if (rsp_utf8_error !== head.utf8_error)
               note_mismatch("utf8_error", 32'(head.utf8_error), 32'(rsp_utf8_error));
         end
      end
   end

   initial begin : rsp_ready_driver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Leaves req_valid high after acceptance; the next request or a drain decides
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] b,
                               input logic [6:0] ti, input logic [20:0] tv);
      int gap;
      gap = (req_gaps_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_data_byte   <= b;
      req_table_index <= ti;
      req_table_value <= tv;
      do @(posedge clock); while (!req_ready);
      encode_request(cmd, b, ti, tv);
   endtask

   task automatic send_utf8(input logic [7:0] b);
      send_request(u8e_pkg::CMD_UTF8, b, 7'($urandom), 21'($urandom_range(0, 'h10FFFF)));
   endtask

   task automatic send_table_write(input logic [1:0] cmd, input logic [6:0] ti,
                                   input logic [20:0] tv);
      send_request(cmd, 8'($urandom), ti, tv);
   endtask

   task automatic send_random_table_write();
      logic [1:0] cmd;
      case ($urandom_range(0, 2))
         0:       cmd = u8e_pkg::CMD_WR_FH;
         1:       cmd = u8e_pkg::CMD_WR_IDX;
         default: cmd = u8e_pkg::CMD_WR_DEC;
      endcase
      send_table_write(cmd, 7'($urandom), 21'($urandom_range(0, 'h10FFFF)));
   endtask

   task automatic send_code_point(input logic [20:0] cp, input int len, input bit mid_write);
      logic [7:0] seq_bytes [4];
      case (len)
         1: seq_bytes[0] = cp[7:0];
         2: begin
            seq_bytes[0] = {3'b110, cp[10:6]};
            seq_bytes[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq_bytes[0] = {4'b1110, cp[15:12]};
            seq_bytes[1] = {2'b10, cp[11:6]};
            seq_bytes[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq_bytes[0] = {5'b11110, cp[20:18]};
            seq_bytes[1] = {2'b10, cp[17:12]};
            seq_bytes[2] = {2'b10, cp[11:6]};
            seq_bytes[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < len; i++) begin
         send_utf8(seq_bytes[i]);
         if (mid_write && i == 0 && len > 1)
            send_random_table_write();
      end
   endtask

   function automatic logic [20:0] random_code_point();
      case ($urandom_range(0, 2))
         0:       return 21'($urandom_range('h80, 'h7FF));
         1:       return 21'($urandom_range('h800, 'hFFFF));
         default: return 21'($urandom_range('h10000, 'h10FFFF));
      endcase
   endfunction

   function automatic int natural_length(logic [20:0] cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   task automatic send_random_unit();
      int          r;
      int          lead_len;
      int          conts;
      logic [20:0] cp;
      logic [7:0]  lead;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         cp = decode_model[$urandom_range(0, 127)];
         send_code_point(cp, natural_length(cp), 1'b0);
      end else if (r < 50) begin
         cp = random_code_point();
         send_code_point(cp, natural_length(cp), 1'b0);
      end else if (r < 65) begin
         send_utf8(8'($urandom_range(0, 'h7F)));
      end else if (r < 70) begin
         send_utf8(8'($urandom_range('h80, 'hBF)));
      end else if (r < 74) begin
         send_utf8(8'($urandom_range('hF8, 'hFF)));
      end else if (r < 79) begin
         // open a sequence, then break it with a non-continuation byte
         lead_len = $urandom_range(2, 4);
         conts = $urandom_range(0, lead_len - 2);
         case (lead_len)
            2:       lead = 8'($urandom_range('hC0, 'hDF));
            3:       lead = 8'($urandom_range('hE0, 'hEF));
            default: lead = 8'($urandom_range('hF0, 'hF7));
         endcase
         send_utf8(lead);
         repeat (conts) send_utf8(8'($urandom_range('h80, 'hBF)));
         case ($urandom_range(0, 2))
            0:       send_utf8(8'($urandom_range(0, 'h7F)));
            1:       send_utf8(8'($urandom_range('hC0, 'hF7)));
            default: send_utf8(8'($urandom_range('hF8, 'hFF)));
         endcase
      end else if (r < 84) begin
         lead_len = $urandom_range(2, 4);
         case (lead_len)
            2:       cp = 21'($urandom_range(0, 'h7F));
            3:       cp = 21'($urandom_range(0, 'h7FF));
            default: cp = 21'($urandom_range(0, 'hFFFF));
         endcase
         send_code_point(cp, lead_len, 1'b0);
      end else if (r < 88) begin
         send_code_point(21'($urandom_range('hD800, 'hDFFF)), 3, 1'b0);
      end else if (r < 92) begin
         send_code_point(21'($urandom_range('h110000, 'h1FFFFF)), 4, 1'b0);
      end else if (r < 96) begin
         send_random_table_write();
      end else begin
         cp = decode_model[$urandom_range(0, 127)];
         send_code_point(cp, natural_length(cp), 1'b1);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [2:0] addr, output logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_default_byte(input logic [7:0] value);
      logic [31:0] readback;
      drain_results();
      csr_write(ADDR_DEFAULT_BYTE, {24'd0, value});
      default_byte_model = value;
      @(posedge clock);
      csr_read(ADDR_DEFAULT_BYTE, readback);
      if (readback[7:0] !== value)
         note_mismatch("default_byte readback", 32'(value), 32'(readback[7:0]));
   endtask

   // Fill every entry of all three tables so that no lookup reads an unwritten one
   task automatic test_load_tables();
      logic [7:0]  fh_plan [128];
      logic [6:0]  ix_plan [128];
      logic [20:0] dc_plan [128];
      bit          ix_set [128];
      logic [6:0]  h;
      logic [20:0] tv;
      for (int k = 0; k < 128; k++) begin
         fh_plan[k] = 8'($urandom_range(0, 255));
         ix_set[k] = 1'b0;
         dc_plan[k] = random_code_point();
         if (dc_plan[k] >= 21'hD800 && dc_plan[k] <= 21'hDFFF)
            dc_plan[k] = dc_plan[k] - 21'h800;
      end
      dc_plan[0] = 21'h80;
      dc_plan[1] = 21'h7FF;
      dc_plan[2] = 21'h800;
      dc_plan[3] = 21'hFFFF;
      dc_plan[4] = 21'h10000;
      dc_plan[5] = 21'h10FFFF;
      // walk down so the lowest entries win a shared hash slot
      for (int k = 127; k >= 0; k--) begin
         h = second_hash(dc_plan[k], fh_plan[dc_plan[k][6:0]]);
         ix_plan[h] = 7'(k);
         ix_set[h] = 1'b1;
      end
      for (int k = 0; k < 128; k++) begin
         if (!ix_set[k]) ix_plan[k] = 7'($urandom);
      end
      for (int k = 0; k < 128; k++) begin
         tv = 21'($urandom_range(0, 'h10FFFF));
         tv[7:0] = fh_plan[k];
         send_table_write(u8e_pkg::CMD_WR_FH, 7'(k), tv);
      end
      for (int k = 0; k < 128; k++)
         send_table_write(u8e_pkg::CMD_WR_DEC, 7'(k), dc_plan[k]);
      for (int k = 0; k < 128; k++) begin
         tv = 21'($urandom_range(0, 'h10FFFF));
         tv[6:0] = ix_plan[k];
         send_table_write(u8e_pkg::CMD_WR_IDX, 7'(k), tv);
      end
   endtask

   task automatic test_directed_cases();
      send_utf8(8'h00);
      send_utf8(8'h7F);
      send_code_point(21'h80, 2, 1'b0);
      send_code_point(21'h7FF, 2, 1'b0);
      // a table write inside a sequence leaves the decoder alone
      send_utf8(8'hF4);
      send_utf8(8'h8F);
      send_table_write(u8e_pkg::CMD_WR_DEC, 7'd5, decode_model[5]);
      send_utf8(8'hBF);
      send_utf8(8'hBF);
      send_utf8(8'hBF);
      send_utf8(8'hFF);
      send_utf8(8'hC3);
      send_utf8(8'h41);
      send_utf8(8'hC1);
      send_utf8(8'hBF);
      send_code_point(21'hD800, 3, 1'b0);
      send_code_point(21'h110000, 4, 1'b0);
      send_code_point(random_code_point(), 3, 1'b0);
   endtask

   task automatic test_random_phase(input logic [7:0] dflt, input bit idle_on, input int units);
      set_default_byte(dflt);
      req_gaps_on = idle_on;
      rsp_stalls_on = idle_on;
      repeat (units) send_random_unit();
   endtask

   // Hold off the result side while requests keep coming until the input stalls
   task automatic test_result_backpressure();
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      rsp_hold_request = 300;
      repeat (40) send_random_unit();
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_truncated_tail();
      send_utf8(8'hE2);
      send_utf8(8'h82);
   endtask

   initial begin : run_tests
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_load_tables();
      test_directed_cases();
      test_random_phase(8'h00, 1'b0, 50);
      test_random_phase(8'hFF, 1'b1, 50);
      test_random_phase(8'($urandom), 1'b1, 50);
      test_result_backpressure();
      test_random_phase(8'($urandom), 1'b1, 50);
      test_truncated_tail();
      drain_results();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
